@@ rtl/core/tlpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared types and constants for the three-level priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int unsigned LevelDepth = 16;
  localparam int unsigned CodeWidth  = 16;
  localparam int unsigned NumLevels  = 3;

  typedef enum logic [1:0] {
    MODE_ENQ      = 2'd0,
    MODE_POP_HEAD = 2'd1,
    MODE_POP_TAIL = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Level indexes: 0 lowest class, 2 highest
  localparam logic [1:0] LvLow  = 2'd0;
  localparam logic [1:0] LvMid  = 2'd1;
  localparam logic [1:0] LvHigh = 2'd2;

  // Requested priorities that select a dedicated level
  localparam logic [1:0] PrioHigh = 2'd3;
  localparam logic [1:0] PrioMid  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  priority_req;
    logic [15:0] code;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  out_priority;
    logic [15:0] out_code;
    logic [5:0]  total_count;
    logic        is_empty;
  } result_t;

  // Registered result info from the controller; code comes from the store
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [1:0] prio;
    logic       take_code;
    logic [5:0] total;
    logic       empty;
  } res_meta_t;

endpackage

@@ rtl/core/three_level_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Strict three-level priority queue, FIFO within a level for head removals, store in one RAM.
// ----------------------------------------------------------------------------
// Result: the result strobe done_o rises in the cycle after a request is taken,
//   the cycle in which the store's registered read data is valid.
// Throughput: one request per cycle; busy stays low, each request makes at most
//   one store access (write for enqueue, read for a removal, none for a clear).
// Reset: pointers and fill counters clear; store contents are left as is.
// Results are shown for one cycle and cannot be stalled.
module three_level_priority_queue #(
  parameter int unsigned LevelDepth = tlpq_pkg::LevelDepth,
  parameter int unsigned CodeWidth  = tlpq_pkg::CodeWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tlpq_pkg::req_t    req_i,
  output logic              done_o,
  output tlpq_pkg::result_t result_o
);

  localparam int unsigned MemDepth = tlpq_pkg::NumLevels * LevelDepth;
  localparam int unsigned AddrW    = $clog2(MemDepth);

  logic                mem_we, mem_re;
  logic [AddrW-1:0]    mem_addr;
  logic [CodeWidth-1:0] mem_wdata, mem_rdata;
  tlpq_pkg::res_meta_t meta;

  // Every request completes in a fixed pipeline, nothing to hold off
  assign busy = 1'b0;

  tlpq_ctrl #(
    .LevelDepth (LevelDepth),
    .CodeWidth  (CodeWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (start && !busy),
    .req_i       (req_i),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .meta_o      (meta)
  );

  tlpq_ram #(
    .Width (CodeWidth),
    .Depth (MemDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign done_o                = meta.valid;
  assign result_o.status       = meta.status;
  assign result_o.out_priority = meta.prio;
  assign result_o.out_code     = meta.take_code ? 16'(mem_rdata) : 16'd0;
  assign result_o.total_count  = meta.total;
  assign result_o.is_empty     = meta.empty;

endmodule

@@ rtl/core/tlpq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module tlpq_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tlpq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_ctrl
// Per-level pointers and fill counters; issues at most one store access per request.
// ----------------------------------------------------------------------------
module tlpq_ctrl #(
  parameter int unsigned LevelDepth = tlpq_pkg::LevelDepth,
  parameter int unsigned CodeWidth  = tlpq_pkg::CodeWidth,
  localparam int unsigned MemDepth  = tlpq_pkg::NumLevels * LevelDepth,
  localparam int unsigned AddrW     = $clog2(MemDepth)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  tlpq_pkg::req_t         req_i,
  output logic                   mem_we_o,
  output logic                   mem_re_o,
  output logic [AddrW-1:0]       mem_addr_o,
  output logic [CodeWidth-1:0]   mem_wdata_o,
  output tlpq_pkg::res_meta_t    meta_o
);

  localparam int unsigned PtrW  = $clog2(LevelDepth);
  localparam int unsigned FillW = $clog2(LevelDepth + 1);
  localparam int unsigned CntW  = $clog2(MemDepth + 1);
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(LevelDepth - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(LevelDepth);
  localparam logic [AddrW-1:0] BaseMid  = AddrW'(LevelDepth);
  localparam logic [AddrW-1:0] BaseHigh = AddrW'(2 * LevelDepth);

  logic [PtrW-1:0]  rd_ptr_q [3];
  logic [PtrW-1:0]  rd_ptr_d [3];
  logic [PtrW-1:0]  wr_ptr_q [3];
  logic [PtrW-1:0]  wr_ptr_d [3];
  logic [FillW-1:0] fill_q   [3];
  logic [FillW-1:0] fill_d   [3];
  tlpq_pkg::res_meta_t meta_q, meta_d;

  tlpq_pkg::mode_e mode;
  logic [1:0]       enq_lv, head_lv, tail_lv, sel_lv;
  logic             any_held, sel_full;
  logic [PtrW-1:0]  sel_rd, sel_wr, sel_wr_dec, acc_ptr;
  logic [FillW-1:0] sel_fill;
  logic [AddrW-1:0] base;
  logic [CntW-1:0]  total_sum;
  logic             do_enq, do_head, do_tail, do_clear;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrLast) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  function automatic logic [PtrW-1:0] wrap_dec(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == '0) ? PtrLast : p - PtrW'(1);
    return r;
  endfunction

  assign mode = tlpq_pkg::mode_e'(req_i.mode);

  // Anything but the two upper priorities lands in the lowest class
  assign enq_lv = (req_i.priority_req == tlpq_pkg::PrioHigh) ? tlpq_pkg::LvHigh :
                  (req_i.priority_req == tlpq_pkg::PrioMid)  ? tlpq_pkg::LvMid  :
                                                               tlpq_pkg::LvLow;

  assign any_held = (fill_q[0] != '0) || (fill_q[1] != '0) || (fill_q[2] != '0);

  assign head_lv = (fill_q[2] != '0) ? tlpq_pkg::LvHigh :
                   (fill_q[1] != '0) ? tlpq_pkg::LvMid  : tlpq_pkg::LvLow;
  assign tail_lv = (fill_q[0] != '0) ? tlpq_pkg::LvLow  :
                   (fill_q[1] != '0) ? tlpq_pkg::LvMid  : tlpq_pkg::LvHigh;

  always_comb begin
    case (mode)
      tlpq_pkg::MODE_ENQ:      sel_lv = enq_lv;
      tlpq_pkg::MODE_POP_HEAD: sel_lv = head_lv;
      tlpq_pkg::MODE_POP_TAIL: sel_lv = tail_lv;
      default:                 sel_lv = tlpq_pkg::LvLow;
    endcase
  end

  assign sel_rd     = rd_ptr_q[sel_lv];
  assign sel_wr     = wr_ptr_q[sel_lv];
  assign sel_fill   = fill_q[sel_lv];
  assign sel_full   = (sel_fill == FillFull);
  assign sel_wr_dec = wrap_dec(sel_wr);

  assign do_enq   = fire_i && (mode == tlpq_pkg::MODE_ENQ) && !sel_full;
  assign do_head  = fire_i && (mode == tlpq_pkg::MODE_POP_HEAD) && any_held;
  assign do_tail  = fire_i && (mode == tlpq_pkg::MODE_POP_TAIL) && any_held;
  assign do_clear = fire_i && (mode == tlpq_pkg::MODE_CLEAR);

  always_comb begin
    case (sel_lv)
      tlpq_pkg::LvMid:  base = BaseMid;
      tlpq_pkg::LvHigh: base = BaseHigh;
      default:          base = '0;
    endcase
  end

  always_comb begin
    case (mode)
      tlpq_pkg::MODE_POP_HEAD: acc_ptr = sel_rd;
      tlpq_pkg::MODE_POP_TAIL: acc_ptr = sel_wr_dec;
      default:                 acc_ptr = sel_wr;
    endcase
  end

  // At most one store access per request, so a read never meets a write in
  // the same cycle; a write is visible to the next request's read.
  assign mem_we_o    = do_enq;
  assign mem_re_o    = do_head || do_tail;
  assign mem_addr_o  = base + AddrW'(acc_ptr);
  assign mem_wdata_o = CodeWidth'(req_i.code);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_ptr_d[i] = rd_ptr_q[i];
      wr_ptr_d[i] = wr_ptr_q[i];
      fill_d[i]   = fill_q[i];
      if (do_clear) begin
        rd_ptr_d[i] = '0;
        wr_ptr_d[i] = '0;
        fill_d[i]   = '0;
      end else if (sel_lv == 2'(i)) begin
        if (do_enq) begin
          wr_ptr_d[i] = wrap_inc(sel_wr);
          fill_d[i]   = sel_fill + FillW'(1);
        end else if (do_head) begin
          rd_ptr_d[i] = wrap_inc(sel_rd);
          fill_d[i]   = sel_fill - FillW'(1);
        end else if (do_tail) begin
          wr_ptr_d[i] = sel_wr_dec;
          fill_d[i]   = sel_fill - FillW'(1);
        end
      end
    end
  end

  assign total_sum = CntW'(fill_d[0]) + CntW'(fill_d[1]) + CntW'(fill_d[2]);

  always_comb begin
    meta_d           = '0;
    meta_d.valid     = fire_i;
    meta_d.total     = 6'(total_sum);
    meta_d.empty     = (total_sum == '0);
    meta_d.take_code = do_head || do_tail;
    meta_d.prio      = (do_head || do_tail) ? sel_lv + 2'd1 : 2'd0;
    if (fire_i && (mode == tlpq_pkg::MODE_ENQ) && sel_full) begin
      meta_d.status = tlpq_pkg::ST_FULL;
    end else if (fire_i && (mode == tlpq_pkg::MODE_POP_HEAD ||
                            mode == tlpq_pkg::MODE_POP_TAIL) && !any_held) begin
      meta_d.status = tlpq_pkg::ST_EMPTY;
    end else begin
      meta_d.status = tlpq_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        fill_q[i]   <= '0;
      end
      meta_q <= '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        rd_ptr_q[i] <= rd_ptr_d[i];
        wr_ptr_q[i] <= wr_ptr_d[i];
        fill_q[i]   <= fill_d[i];
      end
      meta_q <= meta_d;
    end
  end

  assign meta_o = meta_q;

  // Assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[0] <= FillFull) && (fill_q[1] <= FillFull) && (fill_q[2] <= FillFull))
    else $error("level fill above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((fill_q[0] != '0) || (rd_ptr_q[0] == wr_ptr_q[0])) &&
    ((fill_q[1] != '0) || (rd_ptr_q[1] == wr_ptr_q[1])) &&
    ((fill_q[2] != '0) || (rd_ptr_q[2] == wr_ptr_q[2])))
    else $error("empty level with mismatched pointers");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |=> meta_q.valid)
    else $error("request without result");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (mode == tlpq_pkg::MODE_ENQ) && sel_full) |=>
      (meta_q.status == tlpq_pkg::ST_FULL) && $stable(fill_q[0]) &&
      $stable(fill_q[1]) && $stable(fill_q[2]))
    else $error("refused enqueue changed state");

  a_take_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_q.valid |-> (meta_q.take_code == (meta_q.prio != 2'd0)))
    else $error("removed code without level");

endmodule

@@ test/tlpq_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_scoreboard
// Watches the request and result channels of the three-level priority queue,
// keeps its own copy of the level FIFOs, predicts each result and compares
// it field by field with what the queue reports.
// ----------------------------------------------------------------------------
module tlpq_scoreboard
  import tlpq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  req_t    req_i,
  input  logic    done_i,
  input  result_t result_i,
  output int      fail_count_o,
  output int      pending_o,
  output int      checked_o,
  output int      full_refusals_o,
  output int      empty_removals_o,
  output int      peak_total_o
);

  // Shadow copy of the queue
  logic [CodeWidth-1:0] slot_mem [NumLevels][LevelDepth];
  int                   head_idx [NumLevels];
  int                   tail_idx [NumLevels];
  int                   level_cnt[NumLevels];

  result_t              expected_q[$];
  result_t              want;
  result_t              pred;

  function automatic result_t apply_queue_op(req_t r);
    result_t    res;
    logic [1:0] lv;
    int         total;
    bit         hit;
    res   = '0;
    hit   = 1'b0;
    res.status = ST_DONE;
    case (mode_e'(r.mode))
      MODE_ENQ: begin
        if (r.priority_req == PrioHigh) lv = LvHigh;
        else if (r.priority_req == PrioMid) lv = LvMid;
        else lv = LvLow;
        if (level_cnt[lv] >= LevelDepth) begin
          res.status = ST_FULL;
        end else begin
          slot_mem[lv][tail_idx[lv]] = r.code;
          tail_idx[lv] = (tail_idx[lv] + 1) % LevelDepth;
          level_cnt[lv]++;
        end
      end
      MODE_POP_HEAD: begin
        for (int i = NumLevels - 1; i >= 0 && !hit; i--) begin
          if (level_cnt[i] != 0) begin
            res.out_code     = slot_mem[i][head_idx[i]];
            res.out_priority = 2'(i + 1);
            head_idx[i]      = (head_idx[i] + 1) % LevelDepth;
            level_cnt[i]--;
            hit = 1'b1;
          end
        end
        if (!hit) res.status = ST_EMPTY;
      end
      MODE_POP_TAIL: begin
        // tail removal serves the lowest non-empty level, newest entry
        for (int i = 0; i < NumLevels && !hit; i++) begin
          if (level_cnt[i] != 0) begin
            tail_idx[i]      = (tail_idx[i] + LevelDepth - 1) % LevelDepth;
            res.out_code     = slot_mem[i][tail_idx[i]];
            res.out_priority = 2'(i + 1);
            level_cnt[i]--;
            hit = 1'b1;
          end
        end
        if (!hit) res.status = ST_EMPTY;
      end
      default: begin
        for (int i = 0; i < NumLevels; i++) begin
          head_idx[i]  = 0;
          tail_idx[i]  = 0;
          level_cnt[i] = 0;
        end
      end
    endcase
    total = level_cnt[0] + level_cnt[1] + level_cnt[2];
    res.total_count = 6'(total);
    res.is_empty    = (total == 0);
    return res;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLevels; i++) begin
        head_idx[i]  = 0;
        tail_idx[i]  = 0;
        level_cnt[i] = 0;
      end
      expected_q.delete();
      fail_count_o     = 0;
      checked_o        = 0;
      full_refusals_o  = 0;
      empty_removals_o = 0;
      peak_total_o     = 0;
    end else begin
      if ($isunknown(done_i)) begin
        $error("done strobe is unknown");
        fail_count_o++;
      end else if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result strobe with no request outstanding");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", int'(want.status), int'(result_i.status));
          check_field("out_priority", int'(want.out_priority),
                      int'(result_i.out_priority));
          check_field("out_code", int'(want.out_code), int'(result_i.out_code));
          check_field("total_count", int'(want.total_count),
                      int'(result_i.total_count));
          check_field("is_empty", int'(want.is_empty), int'(result_i.is_empty));
          checked_o++;
        end
      end
      if (start_i && !busy_i) begin
        pred = apply_queue_op(req_i);
        if (pred.status == ST_FULL) full_refusals_o++;
        if (pred.status == ST_EMPTY) empty_removals_o++;
        if (int'(pred.total_count) > peak_total_o) peak_total_o = int'(pred.total_count);
        expected_q.push_back(pred);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

@@ test/tb_three_level_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_level_priority_queue
// Drives directed and phased random requests into the priority queue with
// random start gaps; the scoreboard predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_three_level_priority_queue;
  import tlpq_pkg::*;

  localparam int         RandomReqs = 1300;
  localparam int         IdleLimit  = 1000;
  localparam logic [1:0] PrioLowest = 2'd1;
  localparam logic [1:0] PrioZero   = 2'd0;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  req_t    req_i;
  logic    done_o;
  result_t result_o;

  logic    req_taken;
  int      idle_cycles;
  int      fail_count;
  int      pending;
  int      checked;
  int      full_refusals;
  int      empty_removals;
  int      peak_total;

  three_level_priority_queue u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  tlpq_scoreboard u_scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req_i),
    .done_i           (done_o),
    .result_i         (result_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .full_refusals_o  (full_refusals),
    .empty_removals_o (empty_removals),
    .peak_total_o     (peak_total)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    req_taken <= start && !busy;
  end

  // watchdog: cycles with neither a request taken nor a result shown
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no progress for %0d cycles", IdleLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap(bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic mode_e pick_mode(phase_e kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      PH_FILL: begin
        if (r < 1) return MODE_CLEAR;
        if (r < 78) return MODE_ENQ;
        if (r < 89) return MODE_POP_HEAD;
        return MODE_POP_TAIL;
      end
      PH_DRAIN: begin
        if (r < 2) return MODE_CLEAR;
        if (r < 22) return MODE_ENQ;
        if (r < 61) return MODE_POP_HEAD;
        return MODE_POP_TAIL;
      end
      default: begin
        if (r < 2) return MODE_CLEAR;
        if (r < 52) return MODE_ENQ;
        if (r < 76) return MODE_POP_HEAD;
        return MODE_POP_TAIL;
      end
    endcase
  endfunction

  // Called and returns at a falling edge; holds start until the request is taken
  task automatic issue_req(mode_e m, logic [1:0] prio, logic [15:0] code, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start              <= 1'b1;
    req_i.mode         <= m;
    req_i.priority_req <= prio;
    req_i.code         <= code;
    do @(negedge clk_i); while (!req_taken);
  endtask

  initial begin
    phase_e     kind;
    int         len;
    int         sent;
    int         waited;
    bit         no_idle;
    bit         focused;
    logic [1:0] focus_prio;
    logic [1:0] prio;

    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // removals on an empty queue
    issue_req(MODE_POP_HEAD, PrioHigh, 16'h0000, 0);
    issue_req(MODE_POP_TAIL, PrioHigh, 16'hFFFF, 0);
    // priority 0 and 1 share the lowest level
    issue_req(MODE_ENQ, PrioZero, 16'h0000, 0);
    issue_req(MODE_ENQ, PrioLowest, 16'hFFFF, 0);
    issue_req(MODE_ENQ, PrioMid, 16'hA5A5, 1);
    issue_req(MODE_ENQ, PrioHigh, 16'h5A5A, 0);
    issue_req(MODE_POP_HEAD, PrioZero, 16'h0000, 0);
    issue_req(MODE_POP_TAIL, PrioZero, 16'h0000, 2);
    issue_req(MODE_POP_HEAD, PrioZero, 16'h0000, 0);
    issue_req(MODE_POP_TAIL, PrioZero, 16'h0000, 0);
    issue_req(MODE_ENQ, PrioHigh, 16'h1234, 0);
    issue_req(MODE_CLEAR, PrioHigh, 16'hFFFF, 0);
    // fill the top level past its depth: last one is refused
    for (int i = 0; i <= LevelDepth; i++) begin
      issue_req(MODE_ENQ, PrioHigh, 16'($urandom), 0);
    end
    issue_req(MODE_CLEAR, PrioZero, 16'h0000, 0);

    sent = 0;
    while (sent < RandomReqs) begin
      kind       = phase_e'($urandom_range(0, 2));
      len        = $urandom_range(20, 80);
      no_idle    = ($urandom_range(0, 3) == 0);
      focused    = ($urandom_range(0, 1) == 1);
      focus_prio = 2'($urandom_range(0, 3));
      for (int i = 0; i < len; i++) begin
        prio = focused ? focus_prio : 2'($urandom_range(0, 3));
        issue_req(pick_mode(kind), prio, 16'($urandom), draw_gap(no_idle));
        sent++;
      end
    end
    start <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 50) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (3) @(negedge clk_i);

    $display("Checked %0d results; %0d enqueues refused on a full level,", checked,
             full_refusals);
    $display("%0d removals from an empty queue, peak occupancy %0d of %0d.",
             empty_removals, peak_total, NumLevels * LevelDepth);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tlpq_pkg.sv
rtl/core/tlpq_ram.sv
rtl/core/tlpq_ctrl.sv
rtl/core/three_level_priority_queue.sv
test/tlpq_scoreboard.sv
test/tb_three_level_priority_queue.sv
